/* rtl/core/assert_macros.svh */
// assertion macros shared by the looper address generator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPAG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication, disabled during reset
`define LPAG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

/* rtl/core/lpag_pkg.sv */
// types, codes and helper functions for the looper playhead address generator
// no dependencies
`timescale 1ns / 1ps

package lpag_pkg;

   localparam int ADDR_W  = 22;
   localparam int GUARD_W = 20;
   localparam int WIDE_W  = ADDR_W + 2;
   localparam int CSR_W   = 22;
   localparam int CSR_IDX_W = 2;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [GUARD_W-1:0] guard_type;
   typedef logic [WIDE_W-1:0]  wide_type;

   localparam wide_type ADDR_MAX = WIDE_W'((64'd1 << ADDR_W) - 64'd1);
   localparam wide_type WIDE_ONE = WIDE_W'(1);

   localparam logic [CSR_W-1:0]   END_POINT_RESET   = CSR_W'(4194303);
   localparam guard_type          LONG_GUARD_RESET  = GUARD_W'(2205);
   localparam guard_type          SHORT_GUARD_RESET = GUARD_W'(441);
   localparam longint END_EFF_RESET =
      (64'(END_POINT_RESET) > 64'(ADDR_MAX)) ? 64'(ADDR_MAX) : 64'(END_POINT_RESET);
   localparam addr_type OUT_POINT_RESET =
      (END_EFF_RESET > 64'(SHORT_GUARD_RESET)) ?
      ADDR_W'(END_EFF_RESET - 64'(SHORT_GUARD_RESET)) : '0;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_END_POINT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_GUARD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_GUARD = 2'd2;

   // head select codes
   localparam logic [1:0] HEAD_FORWARD  = 2'd0;
   localparam logic [1:0] HEAD_REVERSE  = 2'd1;
   localparam logic [1:0] HEAD_PINGPONG = 2'd2;

   typedef enum logic [2:0] {
      OP_TICK         = 3'd0,
      OP_SET_IN       = 3'd1,
      OP_SET_OUT      = 3'd2,
      OP_RESET_POINTS = 3'd3,
      OP_LOOP_SWITCH  = 3'd4,
      OP_TOGGLE_HEAD  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ENV_NONE = 2'd0,
      ENV_ON   = 2'd1,
      ENV_OFF  = 2'd2
   } env_type;

   typedef struct packed {
      logic [CSR_W-1:0] end_point;
      guard_type        long_guard;
      guard_type        short_guard;
   } cfg_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       loop_enable;
      logic [1:0] head;
   } req_type;

   typedef struct packed {
      addr_type   rec_addr;
      addr_type   forward_addr;
      addr_type   reverse_addr;
      addr_type   pingpong_addr;
      addr_type   loop_start;
      addr_type   loop_end;
      env_type    forward_env;
      env_type    reverse_env;
      env_type    pingpong_env;
      logic [2:0] playing_mask;
   } rsp_type;

   function automatic wide_type sub0(input wide_type a, input wide_type b);
      return (a > b) ? (a - b) : '0;
   endfunction

   function automatic wide_type sat_addr(input wide_type v);
      return (v > ADDR_MAX) ? ADDR_MAX : v;
   endfunction

   function automatic wide_type eff_end(input logic [CSR_W-1:0] end_point);
      return sat_addr(WIDE_W'(end_point));
   endfunction

endpackage

/* rtl/core/looper_playhead_address_generator.sv */
// a request is held in the request register, then its result in the result register, which drives rsp_valid
// throughput: one request per cycle while rsp_ready stays high
// a request is taken whenever the request register is empty or moves on, even with a
// response still waiting; state updates in the cycle the request leaves the request register
// reset empties both register stages and returns pointers, loop points, flags and csr values
`timescale 1ns / 1ps
`include "assert_macros.svh"

// top level: request and result registers around the event engine and csr block
// depends on lpag_pkg, lpag_csr, lpag_engine and assert_macros.svh
module looper_playhead_address_generator
   import lpag_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_operation,
   input  logic                 req_loop_enable,
   input  logic [1:0]           req_head,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_W-1:0]    rsp_rec_addr,
   output logic [ADDR_W-1:0]    rsp_forward_addr,
   output logic [ADDR_W-1:0]    rsp_reverse_addr,
   output logic [ADDR_W-1:0]    rsp_pingpong_addr,
   output logic [ADDR_W-1:0]    rsp_loop_start,
   output logic [ADDR_W-1:0]    rsp_loop_end,
   output logic [1:0]           rsp_forward_env,
   output logic [1:0]           rsp_reverse_env,
   output logic [1:0]           rsp_pingpong_env,
   output logic [2:0]           rsp_playing_mask,

   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance, step, take;

   lpag_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lpag_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      req_in.operation   = req_operation;
      req_in.loop_enable = req_loop_enable;
      req_in.head        = req_head;

      if (take) begin
         req_valid_in = 1'b1;
      end else if (step) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rec_addr      = rsp_ff.rec_addr;
   assign rsp_forward_addr  = rsp_ff.forward_addr;
   assign rsp_reverse_addr  = rsp_ff.reverse_addr;
   assign rsp_pingpong_addr = rsp_ff.pingpong_addr;
   assign rsp_loop_start    = rsp_ff.loop_start;
   assign rsp_loop_end      = rsp_ff.loop_end;
   assign rsp_forward_env   = rsp_ff.forward_env;
   assign rsp_reverse_env   = rsp_ff.reverse_env;
   assign rsp_pingpong_env  = rsp_ff.pingpong_env;
   assign rsp_playing_mask  = rsp_ff.playing_mask;

   `LPAG_ASSERT_NXT(a_step_gives_rsp, clock, reset, step, rsp_valid)
   `LPAG_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_ready, req_valid_ff && !advance)
   `LPAG_ASSERT_NXT(a_drain_clears_rsp, clock, reset, advance && !req_valid_ff, !rsp_valid)

endmodule

/* rtl/core/lpag_csr.sv */
// configuration registers: end point, long and short de-click guards
// depends on lpag_pkg
`timescale 1ns / 1ps

module lpag_csr
   import lpag_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_END_POINT:   cfg_in.end_point   = csr_write_data;
            CSR_LONG_GUARD:  cfg_in.long_guard  = GUARD_W'(csr_write_data);
            CSR_SHORT_GUARD: cfg_in.short_guard = GUARD_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.end_point   <= END_POINT_RESET;
         cfg_ff.long_guard  <= LONG_GUARD_RESET;
         cfg_ff.short_guard <= SHORT_GUARD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/lpag_engine.sv */
// pointer and loop point state with the single-pass event logic
// depends on lpag_pkg
`timescale 1ns / 1ps

module lpag_engine
   import lpag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   addr_type   rec_ff, fw_ff, rv_ff, pp_ff, in_ff, out_ff;
   addr_type   rec_in, fw_in, rv_in, pp_in, in_in, out_in;
   logic       pp_up_ff, pp_up_in;
   logic       looping_ff, looping_in;
   logic [2:0] play_ff, play_in;

   wide_type e, lg, g2, inp, outp;
   wide_type rec, fw, rv, pp, inn, outn;
   logic     dir;
   logic     notify;
   env_type  env_fw, env_rv, env_pp;
   op_type   op;

   assign op = op_type'(req.operation);

   always_comb begin
      e    = eff_end(cfg.end_point);
      lg   = WIDE_W'(cfg.long_guard);
      g2   = lg << 1;
      inp  = WIDE_W'(in_ff);
      outp = WIDE_W'(out_ff);
      rec  = WIDE_W'(rec_ff);
      fw   = WIDE_W'(fw_ff);
      rv   = WIDE_W'(rv_ff);
      pp   = WIDE_W'(pp_ff);
      inn  = inp;
      outn = outp;
      dir  = pp_up_ff;
      looping_in = looping_ff;
      play_in    = play_ff;
      notify = 1'b0;
      env_fw = ENV_NONE;
      env_rv = ENV_NONE;
      env_pp = ENV_NONE;

      case (op)
         OP_TICK: begin
            rec = rec + WIDE_ONE;
            if (!looping_ff) begin
               if (rec > e) rec = '0;
            end else begin
               if (rec > outp) rec = inp;
               if (rec < inp) rec = inp;
            end

            if (!looping_ff) begin
               fw = fw + WIDE_ONE;
               if (fw > e) fw = '0;
               rv = (rv == '0) ? e : (rv - WIDE_ONE);
               if (dir) begin
                  pp = pp + WIDE_ONE;
                  if (pp > e) begin
                     pp  = sub0(e, WIDE_ONE);
                     dir = 1'b0;
                  end
               end else if (pp == '0) begin
                  pp  = WIDE_ONE;
                  dir = 1'b1;
               end else begin
                  pp = pp - WIDE_ONE;
               end
            end else begin
               if (fw < inp) fw = inp;
               if (fw > outp) fw = outp;
               if (rv < inp) rv = inp;
               if (rv > outp) rv = outp;
               if (pp < inp) pp = inp;
               if (pp > outp) pp = outp;

               // forward head wraps from out point to in point
               if (outp >= lg && fw == outp - lg) env_fw = ENV_OFF;
               if (fw == inp) env_fw = ENV_ON;
               fw = fw + WIDE_ONE;
               if (fw > outp) fw = inp;

               // reverse head wraps from in point to out point
               if (rv <= inp) begin
                  rv     = outp;
                  env_rv = ENV_ON;
               end else begin
                  if (rv == inp + lg) env_rv = ENV_OFF;
                  rv = rv - WIDE_ONE;
               end

               // ping-pong head turns at both points
               if (dir) begin
                  if (outp >= lg && pp == outp - lg) env_pp = ENV_OFF;
                  if (pp == inp) env_pp = ENV_ON;
                  pp = pp + WIDE_ONE;
                  if (pp >= outp) begin
                     pp     = outp;
                     dir    = 1'b0;
                     env_pp = ENV_ON;
                  end
               end else begin
                  if (pp == inp + lg) env_pp = ENV_OFF;
                  if (pp == outp) env_pp = ENV_ON;
                  pp = sub0(pp, WIDE_ONE);
                  if (pp <= inp) begin
                     pp     = inp;
                     dir    = 1'b1;
                     env_pp = ENV_ON;
                  end
               end
            end
         end
         OP_SET_IN: begin
            inn = rec;
            if (inn >= outn) outn = e;
            if (inn > outn || (outn - inn) < g2) begin
               inn = sub0(outn, g2);
               if (inn == '0) outn = sat_addr(g2);
            end
            notify = 1'b1;
         end
         OP_SET_OUT: begin
            outn = rec;
            if (outn == '0) outn = sat_addr(g2);
            if (outn > e) outn = e;
            if (outn <= inn) inn = '0;
            if ((outn - inn) < g2) begin
               outn = inn + g2;
               if (outn > e) begin
                  outn = e;
                  inn  = sub0(e, g2);
               end
            end
            notify = 1'b1;
         end
         OP_RESET_POINTS: begin
            inn    = '0;
            outn   = e;
            notify = 1'b1;
         end
         OP_LOOP_SWITCH: begin
            looping_in = req.loop_enable;
            if (req.loop_enable) begin
               rec    = inp;
               fw     = inp;
               rv     = inp;
               pp     = inp;
               notify = 1'b1;
            end
         end
         OP_TOGGLE_HEAD: begin
            case (req.head)
               HEAD_FORWARD:  play_in[0] = ~play_ff[0];
               HEAD_REVERSE:  play_in[1] = ~play_ff[1];
               HEAD_PINGPONG: play_in[2] = ~play_ff[2];
               default: ;
            endcase
         end
         default: ;
      endcase

      // loop point change or loop enable restarts the envelope on every playing head while looping
      if (notify && looping_in) begin
         if (play_in[0]) env_fw = ENV_ON;
         if (play_in[1]) env_rv = ENV_ON;
         if (play_in[2]) env_pp = ENV_ON;
      end

      rec_in   = ADDR_W'(rec);
      fw_in    = ADDR_W'(fw);
      rv_in    = ADDR_W'(rv);
      pp_in    = ADDR_W'(pp);
      in_in    = ADDR_W'(inn);
      out_in   = ADDR_W'(outn);
      pp_up_in = dir;
   end

   always_comb begin
      if (op == OP_TICK) begin
         rsp.rec_addr      = rec_ff;
         rsp.forward_addr  = fw_ff;
         rsp.reverse_addr  = rv_ff;
         rsp.pingpong_addr = pp_ff;
      end else begin
         rsp.rec_addr      = rec_in;
         rsp.forward_addr  = fw_in;
         rsp.reverse_addr  = rv_in;
         rsp.pingpong_addr = pp_in;
      end
      rsp.loop_start   = in_in;
      rsp.loop_end     = out_in;
      rsp.forward_env  = env_fw;
      rsp.reverse_env  = env_rv;
      rsp.pingpong_env = env_pp;
      rsp.playing_mask = play_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff     <= '0;
         fw_ff      <= '0;
         rv_ff      <= '0;
         pp_ff      <= '0;
         pp_up_ff   <= 1'b1;
         in_ff      <= '0;
         out_ff     <= OUT_POINT_RESET;
         looping_ff <= 1'b0;
         play_ff    <= 3'b001;
      end else if (step) begin
         rec_ff     <= rec_in;
         fw_ff      <= fw_in;
         rv_ff      <= rv_in;
         pp_ff      <= pp_in;
         pp_up_ff   <= pp_up_in;
         in_ff      <= in_in;
         out_ff     <= out_in;
         looping_ff <= looping_in;
         play_ff    <= play_in;
      end
   end

endmodule

/* bench/looper_playhead_address_generator_test.sv */
// self-checking bench for the looper playhead address generator: a directed table, then
// random event streams under several register settings and handshake pacing
// depends on lpag_pkg and looper_playhead_address_generator
`timescale 1ns / 1ps

module looper_playhead_address_generator_test;
   import lpag_pkg::*;

   localparam longint unsigned ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam logic [1:0] HEAD_UNUSED = 2'd3;
   localparam rsp_type NO_RESULT = '0;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} pacing_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       loop_enable;
      logic [1:0] head;
      logic       hand_checked;
      rsp_type    want;
   } script_row;

   logic clock;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [2:0]       req_operation = '0;
   logic             req_loop_enable = 1'b0;
   logic [1:0]       req_head = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_rec_addr, rsp_forward_addr, rsp_reverse_addr, rsp_pingpong_addr;
   logic [ADDR_W-1:0] rsp_loop_start, rsp_loop_end;
   logic [1:0]       rsp_forward_env, rsp_reverse_env, rsp_pingpong_env;
   logic [2:0]       rsp_playing_mask;
   logic             csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_write_data = '0;

   pacing_type pacing = IDLE_NONE;
   bit long_hold_wanted = 1'b0;
   int mismatch_count = 0;
   rsp_type pending_playheads [$];

   // predictor state
   logic [CSR_W-1:0]   cfg_end;
   logic [GUARD_W-1:0] cfg_long, cfg_short;
   longint unsigned rec_pos, fwd_pos, rev_pos, pp_pos, loop_in, loop_out;
   bit pp_up, loop_on;
   bit [2:0] heads_on;
   env_type head_event [3];

   script_row opening_script [24] = '{
      '{OP_TICK, 1'b0, HEAD_FORWARD, 1'b1, '{22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b001}},
      '{OP_TICK, 1'b1, HEAD_UNUSED, 1'b1, '{22'd1, 22'd1, 22'd4194303, 22'd1, 22'd0,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b001}},
      '{OP_TOGGLE_HEAD, 1'b0, HEAD_REVERSE, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd0,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b011}},
      '{OP_TOGGLE_HEAD, 1'b1, HEAD_PINGPONG, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd0,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b111}},
      '{OP_TOGGLE_HEAD, 1'b0, HEAD_UNUSED, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd0,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b111}},
      '{OP_SPARE_6, 1'b1, HEAD_PINGPONG, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd0,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b111}},
      '{OP_SPARE_7, 1'b0, HEAD_FORWARD, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd0,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b111}},
      '{OP_SET_IN, 1'b0, HEAD_FORWARD, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd2,
         OUT_POINT_RESET, ENV_NONE, ENV_NONE, ENV_NONE, 3'b111}},
      '{OP_SET_OUT, 1'b0, HEAD_FORWARD, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd0,
         22'd4410, ENV_NONE, ENV_NONE, ENV_NONE, 3'b111}},
      '{OP_RESET_POINTS, 1'b1, HEAD_REVERSE, 1'b1, '{22'd2, 22'd2, 22'd4194302, 22'd2, 22'd0,
         22'd4194303, ENV_NONE, ENV_NONE, ENV_NONE, 3'b111}},
      '{OP_LOOP_SWITCH, 1'b1, HEAD_FORWARD, 1'b1, '{22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
         22'd4194303, ENV_ON, ENV_ON, ENV_ON, 3'b111}},
      '{OP_TICK, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_TOGGLE_HEAD, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_SET_IN, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_TICK, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_TICK, 1'b1, HEAD_PINGPONG, 1'b0, NO_RESULT},
      '{OP_SET_OUT, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_TICK, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_LOOP_SWITCH, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_TICK, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_LOOP_SWITCH, 1'b1, HEAD_UNUSED, 1'b0, NO_RESULT},
      '{OP_TICK, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_TOGGLE_HEAD, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT},
      '{OP_TICK, 1'b0, HEAD_FORWARD, 1'b0, NO_RESULT}
   };

   looper_playhead_address_generator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_loop_enable   (req_loop_enable),
      .req_head          (req_head),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rec_addr      (rsp_rec_addr),
      .rsp_forward_addr  (rsp_forward_addr),
      .rsp_reverse_addr  (rsp_reverse_addr),
      .rsp_pingpong_addr (rsp_pingpong_addr),
      .rsp_loop_start    (rsp_loop_start),
      .rsp_loop_end      (rsp_loop_end),
      .rsp_forward_env   (rsp_forward_env),
      .rsp_reverse_env   (rsp_reverse_env),
      .rsp_pingpong_env  (rsp_pingpong_env),
      .rsp_playing_mask  (rsp_playing_mask),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint unsigned last_sample();
      return (64'(cfg_end) > ADDR_MASK) ? ADDR_MASK : 64'(cfg_end);
   endfunction

   function automatic longint unsigned minus_or_zero(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : 64'd0;
   endfunction

   function automatic longint unsigned clip_addr(longint unsigned v);
      return (v > ADDR_MASK) ? ADDR_MASK : v;
   endfunction

   function automatic longint unsigned hold_in_loop(longint unsigned x);
      if (x < loop_in) x = loop_in;
      if (x > loop_out) x = loop_out;
      return x;
   endfunction

   function automatic void flag_playing_heads();
      if (loop_on)
         for (int h = 0; h < 3; h++)
            if (heads_on[h]) head_event[h] = ENV_ON;
   endfunction

   function automatic void mark_in_point();
      longint unsigned span;
      span = 2 * 64'(cfg_long);
      loop_in = rec_pos & ADDR_MASK;
      if (loop_in >= loop_out) loop_out = last_sample();
      if (loop_in > loop_out || loop_out - loop_in < span) begin
         loop_in = minus_or_zero(loop_out, span);
         if (loop_in == 0) loop_out = clip_addr(span);
      end
   endfunction

   function automatic void mark_out_point();
      longint unsigned span, top;
      span = 2 * 64'(cfg_long);
      top = last_sample();
      loop_out = rec_pos & ADDR_MASK;
      if (loop_out == 0) loop_out = clip_addr(span);
      if (loop_out > top) loop_out = top;
      if (loop_out <= loop_in) loop_in = 0;
      if (loop_out - loop_in < span) begin
         loop_out = loop_in + span;
         if (loop_out > top) begin
            loop_out = top;
            loop_in = minus_or_zero(top, span);
         end
      end
   endfunction

   function automatic void advance_heads();
      longint unsigned top, guard, lo, hi;
      top = last_sample();
      guard = 64'(cfg_long);
      lo = loop_in;
      hi = loop_out;
      rec_pos++;
      if (!loop_on) begin
         if (rec_pos > top) rec_pos = 0;
      end else begin
         if (rec_pos > hi) rec_pos = lo;
         if (rec_pos < lo) rec_pos = lo;
      end
      if (!loop_on) begin
         fwd_pos++;
         if (fwd_pos > top) fwd_pos = 0;
         rev_pos = (rev_pos == 0) ? top : rev_pos - 1;
         if (pp_up) begin
            pp_pos++;
            if (pp_pos > top) begin
               pp_pos = minus_or_zero(top, 1);
               pp_up = 1'b0;
            end
         end else if (pp_pos == 0) begin
            pp_pos = 1;
            pp_up = 1'b1;
         end else begin
            pp_pos--;
         end
      end else begin
         fwd_pos = hold_in_loop(fwd_pos);
         rev_pos = hold_in_loop(rev_pos);
         pp_pos = hold_in_loop(pp_pos);
         if (hi >= guard && fwd_pos == hi - guard) head_event[0] = ENV_OFF;
         if (fwd_pos == lo) head_event[0] = ENV_ON;
         fwd_pos++;
         if (fwd_pos > hi) fwd_pos = lo;
         if (rev_pos <= lo) begin
            rev_pos = hi;
            head_event[1] = ENV_ON;
         end else begin
            if (rev_pos == lo + guard) head_event[1] = ENV_OFF;
            rev_pos--;
         end
         if (pp_up) begin
            if (hi >= guard && pp_pos == hi - guard) head_event[2] = ENV_OFF;
            if (pp_pos == lo) head_event[2] = ENV_ON;
            pp_pos++;
            if (pp_pos >= hi) begin
               pp_pos = hi;
               pp_up = 1'b0;
               head_event[2] = ENV_ON;
            end
         end else begin
            if (pp_pos == lo + guard) head_event[2] = ENV_OFF;
            if (pp_pos == hi) head_event[2] = ENV_ON;
            pp_pos = minus_or_zero(pp_pos, 1);
            if (pp_pos <= lo) begin
               pp_pos = lo;
               pp_up = 1'b1;
               head_event[2] = ENV_ON;
            end
         end
      end
      rec_pos &= ADDR_MASK;
      fwd_pos &= ADDR_MASK;
      rev_pos &= ADDR_MASK;
      pp_pos &= ADDR_MASK;
   endfunction

   function automatic rsp_type step_playheads(logic [2:0] op, logic en, logic [1:0] hd);
      rsp_type r;
      longint unsigned was_rec, was_fwd, was_rev, was_pp;
      head_event[0] = ENV_NONE;
      head_event[1] = ENV_NONE;
      head_event[2] = ENV_NONE;
      was_rec = rec_pos;
      was_fwd = fwd_pos;
      was_rev = rev_pos;
      was_pp = pp_pos;
      case (op)
         OP_TICK: advance_heads();
         OP_SET_IN: begin
            mark_in_point();
            flag_playing_heads();
         end
         OP_SET_OUT: begin
            mark_out_point();
            flag_playing_heads();
         end
         OP_RESET_POINTS: begin
            loop_in = 0;
            loop_out = last_sample();
            flag_playing_heads();
         end
         OP_LOOP_SWITCH: begin
            loop_on = en;
            if (loop_on) begin
               rec_pos = loop_in;
               fwd_pos = loop_in;
               rev_pos = loop_in;
               pp_pos = loop_in;
               flag_playing_heads();
            end
         end
         OP_TOGGLE_HEAD: begin
            if (hd != HEAD_UNUSED) heads_on[hd] = ~heads_on[hd];
         end
         default: ;
      endcase
      if (op != OP_TICK) begin
         was_rec = rec_pos;
         was_fwd = fwd_pos;
         was_rev = rev_pos;
         was_pp = pp_pos;
      end
      r.rec_addr      = ADDR_W'(was_rec);
      r.forward_addr  = ADDR_W'(was_fwd);
      r.reverse_addr  = ADDR_W'(was_rev);
      r.pingpong_addr = ADDR_W'(was_pp);
      r.loop_start    = ADDR_W'(loop_in);
      r.loop_end      = ADDR_W'(loop_out);
      r.forward_env   = head_event[0];
      r.reverse_env   = head_event[1];
      r.pingpong_env  = head_event[2];
      r.playing_mask  = heads_on;
      return r;
   endfunction

   function automatic bit sender_waits();
      case (pacing)
         IDLE_SENDER: return $urandom_range(99) < 86;
         IDLE_BOTH:   return $urandom_range(99) < 32;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (pacing)
         IDLE_RECEIVER: return $urandom_range(99) < 86;
         IDLE_BOTH:     return $urandom_range(99) < 32;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic void compare_field(string label, logic [ADDR_W-1:0] want,
                                         logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   // called at a clock edge; returns at the edge where the request is taken
   task automatic send_request(input logic [2:0] op, input logic en, input logic [1:0] hd,
                               input logic hand_checked, input rsp_type hand_result);
      rsp_type predicted;
      while (sender_waits()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_loop_enable <= en;
      req_head        <= hd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_playheads(op, en, hd);
      pending_playheads.push_back(hand_checked ? hand_result : predicted);
   endtask

   // only with the block drained
   task automatic load_settings(input logic [CSR_W-1:0] last, input logic [GUARD_W-1:0] lg,
                                input logic [GUARD_W-1:0] sg);
      req_valid <= 1'b0;
      while (pending_playheads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_END_POINT;
      csr_write_data   <= last;
      @(posedge clock);
      csr_index      <= CSR_LONG_GUARD;
      csr_write_data <= CSR_W'(lg);
      @(posedge clock);
      csr_index      <= CSR_SHORT_GUARD;
      csr_write_data <= CSR_W'(sg);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_end   = last;
      cfg_long  = lg;
      cfg_short = sg;
   endtask

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !receiver_stalls();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_playheads.size() == 0) begin
            $display("%0t: response with nothing outstanding, rec_addr %0d", $time,
                     rsp_rec_addr);
            mismatch_count++;
         end else begin
            want = pending_playheads.pop_front();
            compare_field("rec_addr", want.rec_addr, rsp_rec_addr);
            compare_field("forward_addr", want.forward_addr, rsp_forward_addr);
            compare_field("reverse_addr", want.reverse_addr, rsp_reverse_addr);
            compare_field("pingpong_addr", want.pingpong_addr, rsp_pingpong_addr);
            compare_field("loop_start", want.loop_start, rsp_loop_start);
            compare_field("loop_end", want.loop_end, rsp_loop_end);
            compare_field("forward_env", ADDR_W'(want.forward_env), ADDR_W'(rsp_forward_env));
            compare_field("reverse_env", ADDR_W'(want.reverse_env), ADDR_W'(rsp_reverse_env));
            compare_field("pingpong_env", ADDR_W'(want.pingpong_env),
                          ADDR_W'(rsp_pingpong_env));
            compare_field("playing_mask", ADDR_W'(want.playing_mask),
                          ADDR_W'(rsp_playing_mask));
         end
      end
   end

   initial begin : stimulus
      logic [2:0] op;
      logic en;
      logic [1:0] hd;
      int pick;
      cfg_end   = END_POINT_RESET;
      cfg_long  = LONG_GUARD_RESET;
      cfg_short = SHORT_GUARD_RESET;
      rec_pos = 0;
      fwd_pos = 0;
      rev_pos = 0;
      pp_pos = 0;
      pp_up = 1'b1;
      loop_in = 0;
      loop_out = minus_or_zero(last_sample(), 64'(cfg_short));
      loop_on = 1'b0;
      heads_on = 3'b001;
      while (reset) @(posedge clock);

      // directed opening at reset settings
      foreach (opening_script[i])
         send_request(opening_script[i].operation, opening_script[i].loop_enable,
                      opening_script[i].head, opening_script[i].hand_checked,
                      opening_script[i].want);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               load_settings(22'd16, 20'd1, 20'd0);
               pacing = IDLE_NONE;
            end
            1: begin
               load_settings(22'd4194303, 20'd1048575, 20'd1048575);
               pacing = IDLE_SENDER;
            end
            2: begin
               load_settings(22'd16, 20'd1048575, GUARD_W'($urandom_range(1048575)));
               pacing = IDLE_RECEIVER;
            end
            3: begin
               load_settings(CSR_W'($urandom_range(300, 16)), GUARD_W'($urandom_range(40, 1)),
                             GUARD_W'($urandom_range(1048575)));
               pacing = IDLE_BOTH;
            end
            4: begin
               load_settings(CSR_W'($urandom_range(200, 16)), GUARD_W'($urandom_range(30, 1)),
                             GUARD_W'($urandom_range(1048575)));
               pacing = IDLE_NONE;
            end
            default: begin
               load_settings(CSR_W'($urandom_range(4000, 16)),
                             GUARD_W'($urandom_range(200, 1)),
                             GUARD_W'($urandom_range(1048575)));
               pacing = IDLE_BOTH;
            end
         endcase
         for (int n = 0; n < 165; n++) begin
            // receiver holds off while requests keep coming, later the sender drains
            if (phase == 4 && n == 30) long_hold_wanted = 1'b1;
            if (phase == 4 && n == 120)
               while (pending_playheads.size() != 0) begin
                  req_valid <= 1'b0;
                  @(posedge clock);
               end
            pick = $urandom_range(99);
            if (pick < 62) op = OP_TICK;
            else if (pick < 69) op = OP_SET_IN;
            else if (pick < 76) op = OP_SET_OUT;
            else if (pick < 79) op = OP_RESET_POINTS;
            else if (pick < 87) op = OP_LOOP_SWITCH;
            else if (pick < 95) op = OP_TOGGLE_HEAD;
            else op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
            en = (op == OP_LOOP_SWITCH) ? ($urandom_range(3) != 0) : 1'($urandom_range(1));
            hd = 2'($urandom_range(3));
            send_request(op, en, hd, 1'b0, NO_RESULT);
         end
      end

      req_valid <= 1'b0;
      while (pending_playheads.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* looper_playhead_address_generator.f */
+incdir+rtl/core
rtl/core/lpag_pkg.sv
rtl/core/lpag_csr.sv
rtl/core/lpag_engine.sv
rtl/core/looper_playhead_address_generator.sv
bench/looper_playhead_address_generator_test.sv
